FILE: design/chacha20_stream_xor_top_defines.svh
// ---------------------------------------------------------------------------
// chacha20 stream xor assertion macros
// shared assertion helpers for the chacha20 stream xor block
// ---------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_XOR_TOP_DEFINES_SVH
`define CHACHA20_STREAM_XOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define CC_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error("fail");
`define CC_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error("fail");
`else
`define CC_ASSERT_IMP(lbl, a, c)
`define CC_ASSERT_NXT(lbl, a, c)
`endif
`endif

FILE: design/ccx_pkg.sv
// ---------------------------------------------------------------------------
// ccx package
// shared types and constants of the chacha20 stream xor block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package ccx_pkg;
	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_NONCE_LO = 3'd4;
	localparam logic [2:0] REG_NONCE_HI = 3'd5;
	localparam logic [2:0] REG_INIT_CTR = 3'd6;

	typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FINAL, ST_OUT} state_t;

	typedef struct packed {
		logic load;      // load initial state
		logic round;     // one column or diagonal round
		logic diag;      // diagonal round when set
		logic fin;       // feed-forward into keystream
		logic restart;   // reload counter from initial_counter
	} cmd_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [127:0] qr(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] a1, b1, c1, d1;
		a1 = a + b;   d1 = rotl(d ^ a1, 16);
		c1 = c + d1;  b1 = rotl(b ^ c1, 12);
		a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
		c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
		qr = {d1, c1, b1, a1};
	endfunction
endpackage

FILE: design/ccx_ctrl.sv
// ---------------------------------------------------------------------------
// ccx controller
// sequences block generation and the byte handshake
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ccx_ctrl #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	input  logic out_ready,
	output logic in_ready,
	output logic out_valid,
	output ccx_pkg::cmd_t cmd,
	output logic [5:0] pos,
	output logic consume
);
	import ccx_pkg::*;
	localparam int RW = $clog2(2 * DOUBLE_ROUNDS + 1);
	state_t state_q, state_d;
	logic [RW-1:0] rnd_q;
	logic [5:0] pos_q;
	logic in_msg_q, have_q, ovalid_q;
	logic need_blk;

	assign need_blk = !have_q;
	assign pos = pos_q;
	assign out_valid = ovalid_q;
	// byte taken when keystream ready and output slot free or draining
	assign in_ready = (state_q == ST_IDLE) && have_q && (!ovalid_q || out_ready);
	assign consume = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid && need_blk) state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == RW'(2 * DOUBLE_ROUNDS - 1)) state_d = ST_FINAL;
			ST_FINAL: state_d = ST_IDLE;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid && need_blk;
				cmd.restart = in_valid && need_blk && !in_msg_q;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				cmd.diag = rnd_q[0];
			end
			ST_FINAL: cmd.fin = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
			pos_q <= '0;
			in_msg_q <= 1'b0;
			have_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ROUND) rnd_q <= rnd_q + 1'b1;
			else rnd_q <= '0;
			if (cmd.load) in_msg_q <= 1'b1;
			if (cmd.fin) have_q <= 1'b1;
			if (consume) begin
				ovalid_q <= 1'b1;
				pos_q <= in_last ? 6'd0 : pos_q + 6'd1;
				if (in_last || pos_q == 6'd63) have_q <= 1'b0;
				if (in_last) in_msg_q <= 1'b0;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end
endmodule

FILE: design/ccx_datapath.sv
// ---------------------------------------------------------------------------
// ccx datapath
// chacha state, one round per cycle, keystream and output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ccx_datapath (
	input  logic clk,
	input  logic arst_n,
	input  ccx_pkg::cmd_t cmd,
	input  logic [5:0] pos,
	input  logic consume,
	input  logic [7:0] data_byte,
	input  logic last_byte,
	input  logic cfg_we,
	input  logic [2:0] cfg_idx,
	input  logic [63:0] cfg_data,
	output logic [7:0] out_byte,
	output logic out_last
);
	import ccx_pkg::*;
	logic [63:0] key_q [4];
	logic [63:0] nonce_lo_q;
	logic [31:0] nonce_hi_q, init_ctr_q, ctr_q;
	logic [31:0] st_q [16];
	logic [31:0] in_q [16];
	logic [31:0] ks_q [16];
	logic [31:0] init_w [16];
	logic [31:0] rnd_w [16];
	logic [31:0] ctr_use;
	logic [31:0] ksw;
	logic [7:0] ob_q;
	logic ol_q;

	assign ctr_use = cmd.restart ? init_ctr_q : ctr_q;

	always_comb begin
		init_w[0] = SIGMA0; init_w[1] = SIGMA1; init_w[2] = SIGMA2; init_w[3] = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init_w[4 + 2 * i] = key_q[i][31:0];
			init_w[5 + 2 * i] = key_q[i][63:32];
		end
		init_w[12] = ctr_use;
		init_w[13] = nonce_lo_q[31:0];
		init_w[14] = nonce_lo_q[63:32];
		init_w[15] = nonce_hi_q;
	end

	// column or diagonal round: four quarter rounds in parallel
	always_comb begin
		logic [127:0] r;
		for (int i = 0; i < 16; i++) rnd_w[i] = st_q[i];
		for (int q = 0; q < 4; q++) begin
			if (!cmd.diag) begin
				r = qr(st_q[q], st_q[4 + q], st_q[8 + q], st_q[12 + q]);
				rnd_w[q] = r[31:0]; rnd_w[4 + q] = r[63:32];
				rnd_w[8 + q] = r[95:64]; rnd_w[12 + q] = r[127:96];
			end else begin
				r = qr(st_q[q], st_q[4 + ((q + 1) % 4)], st_q[8 + ((q + 2) % 4)],
					st_q[12 + ((q + 3) % 4)]);
				rnd_w[q] = r[31:0]; rnd_w[4 + ((q + 1) % 4)] = r[63:32];
				rnd_w[8 + ((q + 2) % 4)] = r[95:64]; rnd_w[12 + ((q + 3) % 4)] = r[127:96];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			nonce_lo_q <= '0;
			nonce_hi_q <= '0;
			init_ctr_q <= '0;
			ctr_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_KEY0: key_q[0] <= cfg_data;
					REG_KEY1: key_q[1] <= cfg_data;
					REG_KEY2: key_q[2] <= cfg_data;
					REG_KEY3: key_q[3] <= cfg_data;
					REG_NONCE_LO: nonce_lo_q <= cfg_data;
					REG_NONCE_HI: nonce_hi_q <= cfg_data[31:0];
					REG_INIT_CTR: init_ctr_q <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (cmd.load) ctr_q <= ctr_use + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 16; i++) begin
				st_q[i] <= init_w[i];
				in_q[i] <= init_w[i];
			end
		end else if (cmd.round) begin
			for (int i = 0; i < 16; i++) st_q[i] <= rnd_w[i];
		end
		if (cmd.fin)
			for (int i = 0; i < 16; i++) ks_q[i] <= st_q[i] + in_q[i];
		if (consume) begin
			ob_q <= data_byte ^ ksw[8 * pos[1:0] +: 8];
			ol_q <= last_byte;
		end
	end

	assign ksw = ks_q[pos[5:2]];
	assign out_byte = ob_q;
	assign out_last = ol_q;
endmodule

FILE: design/chacha20_stream_xor_top.sv
// ---------------------------------------------------------------------------
// chacha20 stream xor top
// xors a byte stream with chacha20 keystream (encrypt and decrypt alike)
// ---------------------------------------------------------------------------
// Each input word is one byte, answered by one output word. At the first byte
// of every 64-byte block (and of every message) the block makes a keystream
// block: a load step, the alternating column and diagonal rounds on a shared
// four quarter-round unit, then a feed-forward step, and takes no byte meanwhile;
// the other 63 bytes of a block pass at one per cycle while the receiver is
// ready. A byte with tlast ends the message and the next one restarts at the
// configured counter. Key and nonce are sampled at each block.
`timescale 1ns / 1ps
`include "chacha20_stream_xor_top_defines.svh"
module chacha20_stream_xor_top #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // data_byte
	input  logic s_tlast,         // last_byte
	output logic m_tvalid,
	input  logic m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic m_tlast,         // out_last
	input  logic cfg_we,
	input  logic [2:0] cfg_idx,
	input  logic [63:0] cfg_data
);
	import ccx_pkg::*;
	cmd_t cmd;
	logic [5:0] pos;
	logic consume;

	ccx_ctrl #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_ctrl (
		.clk, .arst_n, .in_valid(s_tvalid), .in_last(s_tlast), .out_ready(m_tready),
		.in_ready(s_tready), .out_valid(m_tvalid), .cmd, .pos, .consume
	);

	ccx_datapath u_dp (
		.clk, .arst_n, .cmd, .pos, .consume, .data_byte(s_tdata), .last_byte(s_tlast),
		.cfg_we, .cfg_idx, .cfg_data, .out_byte(m_tdata), .out_last(m_tlast)
	);

	// a stalled output word is never overwritten
	`CC_ASSERT_IMP(a_no_overrun, m_tvalid && !m_tready, !s_tready)
	// no byte is taken while a block is being made
	`CC_ASSERT_IMP(a_no_take_busy, cmd.round || cmd.load, !consume)
	// each taken byte shows up as a valid output word next cycle
	`CC_ASSERT_NXT(a_out_follows, consume, m_tvalid)
endmodule

FILE: sim/chacha20_stream_xor_top_test.sv
// ---------------------------------------------------------------------------
// chacha20 stream xor top testbench
// streams message bytes through the block under several keys, nonces and
// counters and checks every output word against a chacha20 keystream predictor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module chacha20_stream_xor_top_test;
	import ccx_pkg::*;

	localparam int DR = 10;
	localparam int BLOCK_CYCLES = 2 * DR + 8;
	// register index with no register behind it
	localparam logic [2:0] REG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_idx = '0;
	logic [63:0] cfg_data = '0;

	chacha20_stream_xor_top #(.DOUBLE_ROUNDS(DR)) dut (.*);

	always #5 clk = ~clk;

	typedef struct packed {
		logic [7:0] cipher;
		logic last;
	} cipher_word_t;

	// predictor copy of the registers and the running cipher state
	logic [63:0] key_q [4];
	logic [63:0] nonce_lo_q;
	logic [31:0] nonce_hi_q;
	logic [31:0] ctr_init_q;
	logic [31:0] blk_ctr;
	logic [5:0] byte_pos;
	logic mid_message;
	logic [31:0] ks_words [16];

	cipher_word_t expected_words[$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int messages = 0;

	task automatic report_mismatch(input string what);
		$display("mismatch at output word %0d: %s", words_checked, what);
		errors++;
	endtask

	function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void mix(ref logic [31:0] w[16], input int a, b, c, d);
		w[a] += w[b]; w[d] = rol32(w[d] ^ w[a], 16);
		w[c] += w[d]; w[b] = rol32(w[b] ^ w[c], 12);
		w[a] += w[b]; w[d] = rol32(w[d] ^ w[a], 8);
		w[c] += w[d]; w[b] = rol32(w[b] ^ w[c], 7);
	endfunction

	// builds one 64-byte keystream block from the current key, nonce and counter
	function automatic void make_keystream();
		logic [31:0] start [16];
		logic [31:0] w [16];
		start[0] = SIGMA0; start[1] = SIGMA1; start[2] = SIGMA2; start[3] = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			start[4 + 2 * i] = key_q[i][31:0];
			start[5 + 2 * i] = key_q[i][63:32];
		end
		start[12] = blk_ctr;
		start[13] = nonce_lo_q[31:0];
		start[14] = nonce_lo_q[63:32];
		start[15] = nonce_hi_q;
		w = start;
		for (int r = 0; r < DR; r++) begin
			mix(w, 0, 4, 8, 12); mix(w, 1, 5, 9, 13);
			mix(w, 2, 6, 10, 14); mix(w, 3, 7, 11, 15);
			mix(w, 0, 5, 10, 15); mix(w, 1, 6, 11, 12);
			mix(w, 2, 7, 8, 13); mix(w, 3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++) ks_words[i] = w[i] + start[i];
	endfunction

	// advances the predictor by one accepted byte and queues the cipher word
	function automatic void predict_cipher(input logic [7:0] data, input logic last);
		cipher_word_t cw;
		logic [7:0] ks;
		if (!mid_message) begin
			blk_ctr = ctr_init_q;
			byte_pos = '0;
			mid_message = 1'b1;
		end
		if (byte_pos == 0) begin
			make_keystream();
			blk_ctr++;
		end
		ks = ks_words[byte_pos[5:2]][8 * byte_pos[1:0] +: 8];
		cw.cipher = data ^ ks;
		cw.last = last;
		expected_words.push_back(cw);
		byte_pos++;
		if (last) begin
			byte_pos = '0;
			mid_message = 1'b0;
			messages++;
		end
	endfunction

	// register write, only called while the block is idle
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			REG_KEY0: key_q[0] = val;
			REG_KEY1: key_q[1] = val;
			REG_KEY2: key_q[2] = val;
			REG_KEY3: key_q[3] = val;
			REG_NONCE_LO: nonce_lo_q = val;
			REG_NONCE_HI: nonce_hi_q = val[31:0];
			REG_INIT_CTR: ctr_init_q = val[31:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_setting(input logic [63:0] k0, k1, k2, k3, nl,
		input logic [31:0] nh, ctr);
		write_reg(REG_KEY0, k0); write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2); write_reg(REG_KEY3, k3);
		write_reg(REG_NONCE_LO, nl); write_reg(REG_NONCE_HI, {32'd0, nh});
		write_reg(REG_INIT_CTR, {32'd0, ctr});
	endtask

	// one input word; random gap before it, inputs change at the falling edge
	task automatic send_byte(input logic [7:0] data, input logic last, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_cipher(data, last);
		words_sent++;
	endtask

	// drop valid right after the last word so no new block is started
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (BLOCK_CYCLES) @(posedge clk);
	endtask

	task automatic send_message(input int len, input bit gaps);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), i == len - 1, gaps);
	endtask

	// receiver stall pattern: random per word, with stall-free stretches
	bit rx_stalls = 1'b1;
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = rx_stalls ? $urandom_range(0, 7) : 0;
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// output checker: compare every accepted word with the oldest prediction
	always @(posedge clk) begin
		cipher_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("output word with nothing expected");
			end else begin
				want = expected_words.pop_front();
				if (m_tdata !== want.cipher)
					report_mismatch($sformatf("byte %02h, want %02h", m_tdata, want.cipher));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
			end
			words_checked++;
		end
	end

	// rfc 8439 style keys, extremes, a one-byte message
	task automatic test_directed();
		load_setting(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h1716151413121110,
			64'h1f1e1d1c1b1a1918, 64'h4a00000000000000, 32'h0, 32'd1);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(8'h55, 1'b0, 1'b0);
		send_byte(8'haa, 1'b1, 1'b0);
		send_byte(8'h80, 1'b1, 1'b0);   // single-byte message
		drain();
		// all ones everywhere, counter wraps to zero after the first block
		load_setting('1, '1, '1, '1, '1, '1, 32'hffffffff);
		send_message(10, 1'b0);
		drain();
	endtask

	// a message crossing block boundaries and a counter wrap
	task automatic test_block_wrap();
		load_setting(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 32'h0, 32'hffffffff);
		send_message(200, 1'b1);
		drain();
	endtask

	// random settings and random message lengths, gaps on both sides
	task automatic test_random();
		for (int s = 0; s < 6; s++) begin
			load_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom}, $urandom,
				(s == 2) ? 32'hfffffffe : $urandom);
			rx_stalls = (s != 3);
			repeat (4) send_message($urandom_range(1, 5) == 1 ? $urandom_range(60, 70)
				: $urandom_range(1, 40), s != 4);
			drain();
		end
		rx_stalls = 1'b1;
		// unknown register index must leave the setting alone
		write_reg(REG_UNUSED, {$urandom, $urandom});
		send_message(20, 1'b1);
		drain();
	endtask

	initial begin
		foreach (key_q[i]) key_q[i] = '0;
		nonce_lo_q = '0; nonce_hi_q = '0; ctr_init_q = '0;
		blk_ctr = '0; byte_pos = '0; mid_message = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_directed();
		test_block_wrap();
		test_random();
		$display("%0d bytes in %0d messages checked (%0d output words), settings incl. extremes",
			words_sent, messages, words_checked);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#3ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+design
design/ccx_pkg.sv
design/ccx_ctrl.sv
design/ccx_datapath.sv
design/chacha20_stream_xor_top.sv
sim/chacha20_stream_xor_top_test.sv
